// ===== rtl/core/id_allocator_free_stack_core_assert.svh =====
// ----------------------------------------------------------------------------
// id_allocator_free_stack_core_assert.svh
// Assertion macros for the ID allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_FREE_STACK_CORE_ASSERT_SVH
`define ID_ALLOCATOR_FREE_STACK_CORE_ASSERT_SVH

// Clocked assertion, off while reset is held
`define IDALLOC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define IDALLOC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/idalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared constants and codes of the ID allocator.
// ----------------------------------------------------------------------------
package idalloc_pkg;

    // Free stack geometry and ID width (ID fields on the ports are 32 bits)
    localparam int FREE_DEPTH = 256;
    localparam int ID_BITS    = 32;
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int ADDR_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

    // Register file: two 32-bit registers at byte offsets 0 and 4
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_UPPER_LIMIT = 1'b0,
        REG_START_VALUE = 1'b1
    } t_reg_sel;

    localparam logic [ID_BITS-1:0] UPPER_LIMIT_RST = '1;
    localparam logic [ID_BITS-1:0] START_VALUE_RST = '0;

    // Request opcodes
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_FREE  = 2'd2
    } t_action;

    // Response status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXHAUSTED  = 3'd1,
        ST_FREE_HIGH  = 3'd2,
        ST_STACK_FULL = 3'd3,
        ST_BLOCK_OVF  = 3'd4
    } t_status;

endpackage

// ===== rtl/core/idalloc_if.sv =====
// ----------------------------------------------------------------------------
// idalloc_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------

// Request channel
interface idalloc_req_if;
    import idalloc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [ID_BITS-1:0] block_count;
    logic [ID_BITS-1:0] free_id;

    modport source (output valid, output action, output block_count, output free_id,
                    input ready);
    modport sink   (input valid, input action, input block_count, input free_id,
                    output ready);
endinterface

// Response channel
interface idalloc_rsp_if;
    import idalloc_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] given_id;
    logic [2:0]         status;

    modport source (output valid, output given_id, output status, input ready);
    modport sink   (input valid, input given_id, input status, output ready);
endinterface

// ===== rtl/core/id_allocator_free_stack_core.sv =====
// ----------------------------------------------------------------------------
// id_allocator_free_stack_core
// Numeric ID allocator: LIFO stack of returned IDs plus a bump pointer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------
//  i_req    | in  | valid / ready     | action, block_count, free_id
//  o_rsp    | out | valid / ready     | given_id, status
//  APB      | in  | psel/penable      | paddr, pwdata, prdata (2 registers)
//
//  Free, block allocate and allocate from the pointer load the result directly.
//  Allocate that pops the stack first waits in S_READ for the free-stack RAM read.
//  One result register; a new transaction is taken in the cycle that the
//  waiting result is taken. Synchronous reset empties the stack at once
//  (stack count only, no clearing pass) and loads the pointer from start.
// ----------------------------------------------------------------------------
`include "id_allocator_free_stack_core_assert.svh"

module id_allocator_free_stack_core
    import idalloc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    idalloc_req_if.sink           i_req,
    idalloc_rsp_if.source         o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [ID_BITS-1:0] r_upper_limit, n_upper_limit;
    logic [ID_BITS-1:0] r_start_value, n_start_value;
    logic [ID_BITS-1:0] r_bump, n_bump;
    logic [CNT_W-1:0]   r_stack_count, n_stack_count;
    logic               r_out_valid, n_out_valid;
    logic [ID_BITS-1:0] r_out_id, n_out_id;
    t_status            r_out_status, n_out_status;

    logic               w_out_free;
    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_pop;
    logic               w_push;
    logic [CNT_W-1:0]   w_cnt_dec;
    logic [ID_BITS:0]   w_block_end;
    logic [ID_BITS-1:0] w_ram_rdata;

    // Handshakes
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_cfg_wr    = psel && penable && pwrite;

    // APB read side
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_START_VALUE) ? r_start_value : r_upper_limit;

    // Stack access decode
    assign w_cnt_dec   = r_stack_count - CNT_W'(1);
    assign w_pop       = w_accept && (i_req.action == ACT_ALLOC) && (r_stack_count != '0);
    assign w_push      = w_accept && (i_req.action == ACT_FREE)
                         && (i_req.free_id <= r_upper_limit)
                         && (r_stack_count < CNT_W'(FREE_DEPTH));
    assign w_block_end = {1'b0, r_bump} + {1'b0, i_req.block_count};

    // Free stack storage
    idalloc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (FREE_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_stack_count[ADDR_W-1:0]),
        .i_wdata (i_req.free_id),
        .i_re    (w_pop),
        .i_raddr (w_cnt_dec[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Request decode and next state
    always_comb begin
        n_state       = r_state;
        n_upper_limit = r_upper_limit;
        n_start_value = r_start_value;
        n_bump        = r_bump;
        n_stack_count = r_stack_count;
        n_out_valid   = r_out_valid;
        n_out_id      = r_out_id;
        n_out_status  = r_out_status;

        if (r_state == S_READ) begin
            // popped ID arrives from the RAM
            n_out_valid  = 1'b1;
            n_out_id     = w_ram_rdata;
            n_out_status = ST_OK;
            n_state      = S_IDLE;
        end else if (w_accept) begin
            n_out_valid  = 1'b1;
            n_out_id     = '0;
            n_out_status = ST_OK;
            case (i_req.action)
                ACT_ALLOC: begin
                    if (w_pop) begin
                        n_stack_count = w_cnt_dec;
                        n_out_valid   = 1'b0;
                        n_state       = S_READ;
                    end else if (r_bump >= r_upper_limit) begin
                        n_out_status = ST_EXHAUSTED;
                    end else begin
                        n_bump   = r_bump + ID_BITS'(1);
                        n_out_id = r_bump + ID_BITS'(1);
                    end
                end
                ACT_BLOCK: begin
                    if (w_block_end > {1'b0, r_upper_limit}) begin
                        n_out_status = ST_BLOCK_OVF;
                    end else begin
                        n_out_id = r_bump;
                        n_bump   = w_block_end[ID_BITS-1:0];
                    end
                end
                ACT_FREE: begin
                    if (i_req.free_id > r_upper_limit) begin
                        n_out_status = ST_FREE_HIGH;
                    end else if (!w_push) begin
                        n_out_status = ST_STACK_FULL;
                    end else begin
                        n_stack_count = r_stack_count + CNT_W'(1);
                    end
                end
                default: begin
                    n_out_status = ST_OK;
                end
            endcase
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // Register writes: to be made only while idle; the block does not enforce it
        if (w_cfg_wr) begin
            if (paddr[2] == REG_START_VALUE) begin
                n_start_value = pwdata;
                n_bump        = pwdata;
            end else begin
                n_upper_limit = pwdata;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_upper_limit <= UPPER_LIMIT_RST;
            r_start_value <= START_VALUE_RST;
            r_bump        <= START_VALUE_RST;
            r_stack_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_upper_limit <= n_upper_limit;
            r_start_value <= n_start_value;
            r_bump        <= n_bump;
            r_stack_count <= n_stack_count;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.given_id = r_out_id;
    assign o_rsp.status   = r_out_status;

    // Checks
    `IDALLOC_ASSERT(a_count_bound, (r_stack_count <= CNT_W'(FREE_DEPTH)),
        "stack count above depth")
    `IDALLOC_ASSERT(a_read_slot_free, (r_state == S_READ) |-> !r_out_valid,
        "result register busy during stack read")
    `IDALLOC_ASSERT(a_pop_sequence,
        w_pop |=> (r_state == S_READ) && (r_stack_count == $past(w_cnt_dec)),
        "pop did not enter read with count decremented")
    `IDALLOC_ASSERT(a_full_refusal,
        (r_out_valid && (r_out_status == ST_STACK_FULL)) |->
            (r_stack_count == CNT_W'(FREE_DEPTH)),
        "stack full reported with room left")
    `IDALLOC_ASSERT_ALWAYS(a_state_onehot, $onehot(r_state) || !i_rst_n,
        "state register not one-hot")

endmodule

// ===== rtl/core/idalloc_ram.sv =====
// ----------------------------------------------------------------------------
// idalloc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module idalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/id_allocator_free_stack_core_test.sv =====
// ----------------------------------------------------------------------------
// id_allocator_free_stack_core_test
// Self-checking bench for the free-stack ID allocator. A tracker class keeps
// its own copy of the free stack, bump pointer and limit, predicts the
// response of every accepted request and checks responses in order.
// Directed requests cover the edge cases, then randomized phases under
// several register settings run with random stalls on both channels.
// ----------------------------------------------------------------------------
module id_allocator_free_stack_core_test
    import idalloc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [31:0] given_id;
        t_status     status;
    } t_grant;

    // Tracks allocator state and the responses still owed by the DUT
    class t_id_pool_tracker;
        logic [31:0] limit;
        logic [31:0] ptr;
        logic [31:0] stack [FREE_DEPTH];
        int          depth_used;
        t_grant      owed[$];
        int unsigned mismatches;

        function new();
            limit      = UPPER_LIMIT_RST;
            ptr        = START_VALUE_RST;
            depth_used = 0;
            mismatches = 0;
        endfunction

        // Writing the start register reloads the pointer, stack untouched
        function void load_start(logic [31:0] value);
            ptr = value;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected 0x%08h, got 0x%08h", what, want, got);
        endfunction

        // Work out the response of one accepted request
        function void take_request(logic [1:0] act, logic [31:0] count, logic [31:0] fid);
            t_grant      g;
            logic [32:0] span;
            g.given_id = '0;
            g.status   = ST_OK;
            case (act)
                ACT_ALLOC: begin
                    if (depth_used > 0) begin
                        depth_used--;
                        g.given_id = stack[depth_used];
                    end else if (ptr >= limit) begin
                        g.status = ST_EXHAUSTED;
                    end else begin
                        ptr        = ptr + 32'd1;
                        g.given_id = ptr;
                    end
                end
                ACT_BLOCK: begin
                    // no wrap allowed: compare with a carry bit
                    span = {1'b0, ptr} + {1'b0, count};
                    if (span > {1'b0, limit}) begin
                        g.status = ST_BLOCK_OVF;
                    end else begin
                        g.given_id = ptr;
                        ptr        = span[31:0];
                    end
                end
                ACT_FREE: begin
                    if (fid > limit) begin
                        g.status = ST_FREE_HIGH;
                    end else if (depth_used >= FREE_DEPTH) begin
                        g.status = ST_STACK_FULL;
                    end else begin
                        stack[depth_used] = fid;
                        depth_used++;
                    end
                end
                default: ;
            endcase
            owed.insert(owed.size(), g);
        endfunction

        function void check_grant(logic [31:0] id, logic [2:0] st);
            t_grant want;
            if (owed.size() == 0) begin
                flag("response with nothing outstanding", '0, id);
                return;
            end
            want = owed.pop_front();
            if (id !== want.given_id)
                flag("given_id", want.given_id, id);
            if (st !== want.status)
                flag("status", 32'(want.status), 32'(st));
        endfunction

        // Anything still owed at the end is a failure
        function void close_out();
            if (owed.size() != 0)
                flag("responses never received", 32'(owed.size()), '0);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    bit          no_idle;
    int unsigned sent_count;
    int unsigned quiet_cycles;

    t_id_pool_tracker ledger = new();

    idalloc_req_if req_ch ();
    idalloc_rsp_if rsp_ch ();

    id_allocator_free_stack_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            ledger.check_grant(rsp_ch.given_id, rsp_ch.status);
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("id_allocator_free_stack_core_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response ready: random stall bursts, long open stretches now and then
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat (40) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // One request transaction, with an optional gap in front
    task automatic send_request(input logic [1:0] act, input logic [31:0] count,
                                input logic [31:0] fid);
        if (!no_idle && (sent_count % 64) < 44 && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.block_count <= count;
        req_ch.free_id     <= fid;
        do @(posedge i_clk); while (!req_ch.ready);
        ledger.take_request(act, count, fid);
        sent_count++;
    endtask

    // Hold requests off until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.owed.size() != 0);
    endtask

    // Idle long enough for a pop still in the pipe to finish
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read-back check
    task automatic reg_write(input t_reg_sel sel, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_UPPER_LIMIT)
            ledger.limit = value;
        else
            ledger.load_start(value);
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
            ledger.flag("register read-back", value, readback);
        @(posedge i_clk);
    endtask

    // Randomized request; free/alloc/block weights in percent, rest unused
    task automatic random_request(input int free_pct, input int alloc_pct,
                                  input int block_pct);
        int          r;
        logic [1:0]  act;
        logic [31:0] count;
        logic [31:0] fid;
        r     = $urandom_range(0, 99);
        count = $urandom;
        fid   = $urandom;
        if (r < free_pct)
            act = ACT_FREE;
        else if (r < free_pct + alloc_pct)
            act = ACT_ALLOC;
        else if (r < free_pct + alloc_pct + block_pct)
            act = ACT_BLOCK;
        else
            act = ACT_UNUSED;

        // block size: mostly small, some exact fits to the limit
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: count = $urandom_range(0, 8);
            5:             count = $urandom;
            6: begin
                if (ledger.ptr <= ledger.limit)
                    count = ledger.limit - ledger.ptr + $urandom_range(0, 1);
                else
                    count = $urandom_range(0, 3);
            end
            7:             count = '0;
            default:       count = $urandom_range(0, 2000);
        endcase

        // freed ID: mostly legal, some at or above the limit
        case ($urandom_range(0, 7))
            0: fid = $urandom;
            1: fid = ledger.limit;
            2: begin
                if (ledger.limit != '1)
                    fid = ledger.limit + 32'd1 + $urandom_range(0, ~ledger.limit - 32'd1);
            end
            default: fid = $urandom_range(0, ledger.limit);
        endcase

        send_request(act, count, fid);
    endtask

    task automatic run_phase(input logic [31:0] lim, input logic [31:0] start, input int n,
                             input int free_pct, input int alloc_pct, input int block_pct);
        settle();
        reg_write(REG_UPPER_LIMIT, lim);
        reg_write(REG_START_VALUE, start);
        for (int i = 0; i < n; i++) begin
            // sender pause mid-phase until the DUT has answered everything
            if (i == n / 2)
                drain();
            random_request(free_pct, alloc_pct, block_pct);
        end
    endtask

    // Stimulus
    initial begin
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_ALLOC;
        req_ch.block_count = '0;
        req_ch.free_id     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        no_idle    = 1'b0;
        sent_count = 0;
        i_rst_n    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default registers, pointer from 0 up to the top
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_BLOCK, 32'd0, $urandom);
        send_request(ACT_BLOCK, 32'd5, $urandom);
        send_request(ACT_BLOCK, 32'hFFFF_FFFF, $urandom);  // overflow
        send_request(ACT_BLOCK, 32'hFFFF_FFF8, $urandom);  // exact fit to limit
        send_request(ACT_ALLOC, $urandom, $urandom);       // exhausted
        send_request(ACT_BLOCK, 32'd0, $urandom);          // zero count at limit
        send_request(ACT_BLOCK, 32'd1, $urandom);
        send_request(ACT_FREE, $urandom, 32'hFFFF_FFFF);
        send_request(ACT_FREE, $urandom, 32'd0);
        send_request(ACT_FREE, $urandom, 32'hA5A5_5A5A);
        send_request(ACT_UNUSED, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom);       // pops, newest first
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_FREE, $urandom, 32'd1000);

        // Directed: lower the limit below an ID still on the stack
        settle();
        reg_write(REG_UPPER_LIMIT, 32'd10);
        reg_write(REG_START_VALUE, 32'd8);
        send_request(ACT_ALLOC, $urandom, $urandom);       // pops 1000
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom);
        send_request(ACT_ALLOC, $urandom, $urandom);       // exhausted
        send_request(ACT_FREE, $urandom, 32'd11);          // above limit
        send_request(ACT_FREE, $urandom, 32'd10);
        send_request(ACT_BLOCK, 32'd0, $urandom);
        send_request(ACT_BLOCK, 32'd1, $urandom);

        // Random phases
        run_phase(32'd40, 32'd0, 120, 40, 40, 15);
        // free-heavy near the top of the ID space: fills the stack
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFF0, 330, 92, 6, 2);
        // zero limit: drains old IDs above the limit, then exhausts
        run_phase(32'd0, 32'd0, 250, 20, 70, 8);
        // pointer already past the limit
        run_phase(32'd1000, 32'd2000, 120, 35, 45, 18);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 30, 50, 18);
        run_phase($urandom_range(1, 5000), $urandom_range(0, 500), 120, 35, 40, 23);
        run_phase($urandom, $urandom, 120, 35, 40, 23);

        // Last stretch without idling
        settle();
        no_idle = 1'b1;
        run_phase($urandom_range(32'h1000_0000, 32'hFFFF_FFFF), 32'd0, 150, 35, 40, 23);

        drain();
        repeat (10) @(posedge i_clk);
        ledger.close_out();
        if (ledger.mismatches == 0)
            $display("id_allocator_free_stack_core_test passed");
        else
            $display("id_allocator_free_stack_core_test failed");
        $finish;
    end

endmodule
